@@ design/bfid_pkg.sv @@
package bfid_pkg;

	// fixed field widths
	localparam int CFG_W     = 13;
	localparam int GRID_W    = 9;
	localparam int IDX_W     = 8;
	localparam int PIX_W     = 8;
	localparam int REG_IDX_W = 3;

	// grid index range of the output fields
	localparam int GRID_INDEX_LIMIT = 256;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLING_MODE = 3'd4;

	// sampling modes
	localparam logic MODE_POINT = 1'b0;
	localparam logic MODE_AREA  = 1'b1;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// band memory control
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

endpackage

@@ design/bfid_div.sv @@
module bfid_div #(
	parameter int W = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	output bfid_pkg::div_stat_t stat,
	output logic [W-1:0]        quot
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       rem_sh;

	// one restoring step per cycle
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= CNT_W'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule

@@ design/bfid_band_mem.sv @@
module bfid_band_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfid_pkg::mem_ctl_t ctl,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [DATA_W-1:0]  wdata,
	output logic [DATA_W-1:0]  rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	// valid bits, cleared together at reset and frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvld_q <= vld_q[addr];
			end
		end
	end

	// an entry not written since the last clear reads as zero
	assign rdata = rvld_q ? rdata_q : '0;

endmodule

@@ design/box_filter_image_downscale_unit.sv @@
// per pixel: a column and a row division, a band memory read and an update; in area mode three
// mean divisions and an output step on a cell's last pixel; in point mode two center divisions,
// a check and, if it emits a cell, an output step, held by a stalled earlier result; no pixel is
// taken until the last is done; all divisions share one bit-serial divider as wide as the sums
// (34 bits by default); a result waits in an output register while the next pixel is taken
// reset: registers take their reset values, band memory valid bits and counters clear
module box_filter_image_downscale_unit #(
	parameter int MAX_GRID_COLUMNS = 256,
	parameter int MAX_SOURCE_SIDE  = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bfid_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bfid_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          frame_start,
	input  logic [bfid_pkg::PIX_W-1:0]    pixel_red,
	input  logic [bfid_pkg::PIX_W-1:0]    pixel_green,
	input  logic [bfid_pkg::PIX_W-1:0]    pixel_blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfid_pkg::IDX_W-1:0]    cell_column,
	output logic [bfid_pkg::IDX_W-1:0]    cell_row,
	output logic [bfid_pkg::PIX_W-1:0]    cell_red,
	output logic [bfid_pkg::PIX_W-1:0]    cell_green,
	output logic [bfid_pkg::PIX_W-1:0]    cell_blue,
	output logic                          frame_done
);

	localparam int POS_W  = $clog2(MAX_SOURCE_SIDE + 1);
	localparam int COL_W  = (MAX_GRID_COLUMNS > 1) ? $clog2(MAX_GRID_COLUMNS) : 1;
	localparam int GCMAX  = (MAX_GRID_COLUMNS < bfid_pkg::GRID_INDEX_LIMIT) ?
		MAX_GRID_COLUMNS : bfid_pkg::GRID_INDEX_LIMIT;
	localparam int CNT_W  = 2 * POS_W;
	localparam int SUM_W  = CNT_W + bfid_pkg::PIX_W;
	localparam int DIV_W  = SUM_W;
	localparam int MUL_W  = POS_W + bfid_pkg::GRID_W + 2;
	localparam int MEM_W  = CNT_W + 3 * SUM_W;
	localparam int GW     = bfid_pkg::GRID_W;
	localparam int PW     = bfid_pkg::PIX_W;
	localparam int IW     = bfid_pkg::IDX_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DC, S_DR, S_RD, S_UPD, S_MR, S_MG, S_MB, S_PC, S_PR, S_CHK, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bfid_pkg::CFG_W-1:0] source_width_q, source_height_q;
	logic [GW-1:0]              grid_columns_q, grid_rows_q;
	logic                       sampling_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= bfid_pkg::CFG_W'(256);
			source_height_q <= bfid_pkg::CFG_W'(256);
			grid_columns_q  <= GW'(64);
			grid_rows_q     <= GW'(64);
			sampling_mode_q <= bfid_pkg::MODE_AREA;
		end else if (cfg_write) begin
			case (cfg_index)
				bfid_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				bfid_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				bfid_pkg::REG_GRID_COLUMNS:  grid_columns_q  <= cfg_data[GW-1:0];
				bfid_pkg::REG_GRID_ROWS:     grid_rows_q     <= cfg_data[GW-1:0];
				bfid_pkg::REG_SAMPLING_MODE: sampling_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective sizes after saturation
	logic [POS_W-1:0] sw, sh;
	logic [GW-1:0]    gc, gr;
	logic [31:0]      lim_c, lim_r;

	always_comb begin
		if (source_width_q == '0) sw = POS_W'(1);
		else if (32'(source_width_q) > 32'(MAX_SOURCE_SIDE)) sw = POS_W'(MAX_SOURCE_SIDE);
		else sw = POS_W'(source_width_q);
		if (source_height_q == '0) sh = POS_W'(1);
		else if (32'(source_height_q) > 32'(MAX_SOURCE_SIDE)) sh = POS_W'(MAX_SOURCE_SIDE);
		else sh = POS_W'(source_height_q);
		lim_c = (32'(GCMAX) < 32'(sw)) ? 32'(GCMAX) : 32'(sw);
		lim_r = (32'(bfid_pkg::GRID_INDEX_LIMIT) < 32'(sh)) ?
			32'(bfid_pkg::GRID_INDEX_LIMIT) : 32'(sh);
		if (grid_columns_q == '0) gc = GW'(1);
		else if (32'(grid_columns_q) > lim_c) gc = GW'(lim_c);
		else gc = grid_columns_q;
		if (grid_rows_q == '0) gr = GW'(1);
		else if (32'(grid_rows_q) > lim_r) gr = GW'(lim_r);
		else gr = grid_rows_q;
	end

	logic [POS_W-1:0] pixel_x_q, pixel_y_q, x_q, y_q;
	logic [PW-1:0]    pix_r_q, pix_g_q, pix_b_q;
	logic [IW-1:0]    c_q, row_q;
	logic [GW-1:0]    pc_q, pr_q;
	logic             col_last_q, row_last_q, pc_ok_q, div_run_q;
	logic [SUM_W-1:0] tot_r_q, tot_g_q, tot_b_q;
	logic [CNT_W-1:0] tot_n_q;
	logic [PW-1:0]    res_r_q, res_g_q, res_b_q;
	logic [IW-1:0]    res_col_q, res_row_q;
	logic             res_done_q;
	logic             out_valid_q;
	logic [IW-1:0]    out_col_q, out_row_q;
	logic [PW-1:0]    out_r_q, out_g_q, out_b_q;
	logic             out_done_q;

	// position of an incoming pixel
	logic [POS_W-1:0] x0, y0;

	always_comb begin
		x0 = frame_start ? '0 : pixel_x_q;
		y0 = frame_start ? '0 : pixel_y_q;
		if (x0 >= sw) begin
			x0 = '0;
			y0 = y0 + 1'b1;
		end
		if (y0 >= sh) y0 = '0;
	end

	// shared divider
	logic                start;
	logic [DIV_W-1:0]    div_num, div_den, quot;
	bfid_pkg::div_stat_t div_st;
	logic                div_state;

	assign div_state = (state_q == S_DC) || (state_q == S_DR) || (state_q == S_MR) ||
		(state_q == S_MG) || (state_q == S_MB) || (state_q == S_PC) || (state_q == S_PR);
	assign start = div_state && !div_run_q;

	always_comb begin
		div_num = '0;
		div_den = DIV_W'(1);
		case (state_q)
			S_DC: begin
				div_num = (DIV_W'(x_q) + 1'b1) * DIV_W'(gc) - 1'b1;
				div_den = DIV_W'(sw);
			end
			S_DR: begin
				div_num = (DIV_W'(y_q) + 1'b1) * DIV_W'(gr) - 1'b1;
				div_den = DIV_W'(sh);
			end
			S_MR: begin
				div_num = DIV_W'(tot_r_q);
				div_den = DIV_W'(tot_n_q);
			end
			S_MG: begin
				div_num = DIV_W'(tot_g_q);
				div_den = DIV_W'(tot_n_q);
			end
			S_MB: begin
				div_num = DIV_W'(tot_b_q);
				div_den = DIV_W'(tot_n_q);
			end
			S_PC: begin
				div_num = DIV_W'(2) * DIV_W'(gc) * DIV_W'(x_q) + DIV_W'(sw) - 1'b1;
				div_den = DIV_W'(sw) << 1;
			end
			S_PR: begin
				div_num = DIV_W'(2) * DIV_W'(gr) * DIV_W'(y_q) + DIV_W'(sh) - 1'b1;
				div_den = DIV_W'(sh) << 1;
			end
			default: ;
		endcase
	end

	bfid_div #(.W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_st),
		.quot   (quot)
	);

	// band memory: {count, blue, green, red} per column band
	bfid_pkg::mem_ctl_t mem_ctl;
	logic [MEM_W-1:0]   mem_wdata, mem_rdata;
	logic [SUM_W-1:0]   old_r, old_g, old_b, new_r, new_g, new_b;
	logic [CNT_W-1:0]   old_n, new_n;
	logic               cell_last;

	assign {old_n, old_b, old_g, old_r} = mem_rdata;
	assign new_r     = old_r + SUM_W'(pix_r_q);
	assign new_g     = old_g + SUM_W'(pix_g_q);
	assign new_b     = old_b + SUM_W'(pix_b_q);
	assign new_n     = old_n + 1'b1;
	assign cell_last = col_last_q && row_last_q;
	assign mem_wdata = cell_last ? '0 : {new_n, new_b, new_g, new_r};

	assign mem_ctl.rd  = (state_q == S_RD);
	assign mem_ctl.wr  = (state_q == S_UPD);
	assign mem_ctl.clr = (state_q == S_IDLE) && in_valid && frame_start;

	bfid_band_mem #(
		.DEPTH  (MAX_GRID_COLUMNS),
		.ADDR_W (COL_W),
		.DATA_W (MEM_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (COL_W'(c_q)),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	// cell edge and center tests
	logic col_last_d, row_last_d, pc_ok_d, pr_ok_d;

	assign col_last_d = ((MUL_W'(c_q) + 1'b1) * MUL_W'(sw)) <
		((MUL_W'(x_q) + MUL_W'(2)) * MUL_W'(gc));
	assign row_last_d = ((MUL_W'(row_q) + 1'b1) * MUL_W'(sh)) <
		((MUL_W'(y_q) + MUL_W'(2)) * MUL_W'(gr));
	assign pc_ok_d = (pc_q < gc) && (((MUL_W'(pc_q) << 1) + 1'b1) * MUL_W'(sw) <
		(MUL_W'(gc) << 1) * (MUL_W'(x_q) + 1'b1));
	assign pr_ok_d = (pr_q < gr) && (((MUL_W'(pr_q) << 1) + 1'b1) * MUL_W'(sh) <
		(MUL_W'(gr) << 1) * (MUL_W'(y_q) + 1'b1));

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			div_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT)) out_valid_q <= 1'b0;
			if (start) div_run_q <= 1'b1;
			if (div_st.done) div_run_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q     <= x0;
						y_q     <= y0;
						pix_r_q <= pixel_red;
						pix_g_q <= pixel_green;
						pix_b_q <= pixel_blue;
						if ((x0 + 1'b1) >= sw) begin
							pixel_x_q <= '0;
							pixel_y_q <= ((y0 + 1'b1) >= sh) ? '0 : y0 + 1'b1;
						end else begin
							pixel_x_q <= x0 + 1'b1;
							pixel_y_q <= y0;
						end
						state_q <= S_DC;
					end
				end
				S_DC: begin
					if (div_st.done) begin
						c_q     <= IW'(quot);
						state_q <= S_DR;
					end
				end
				S_DR: begin
					if (start) col_last_q <= col_last_d;
					if (div_st.done) begin
						row_q   <= IW'(quot);
						state_q <= S_RD;
					end
				end
				S_RD: begin
					row_last_q <= row_last_d;
					state_q    <= S_UPD;
				end
				S_UPD: begin
					tot_r_q    <= new_r;
					tot_g_q    <= new_g;
					tot_b_q    <= new_b;
					tot_n_q    <= new_n;
					res_col_q  <= c_q;
					res_row_q  <= row_q;
					res_done_q <= (GW'(c_q) == gc - 1'b1) && (GW'(row_q) == gr - 1'b1);
					if (sampling_mode_q == bfid_pkg::MODE_POINT) state_q <= S_PC;
					else if (cell_last) state_q <= S_MR;
					else state_q <= S_IDLE;
				end
				S_MR: begin
					if (div_st.done) begin
						res_r_q <= PW'(quot);
						state_q <= S_MG;
					end
				end
				S_MG: begin
					if (div_st.done) begin
						res_g_q <= PW'(quot);
						state_q <= S_MB;
					end
				end
				S_MB: begin
					if (div_st.done) begin
						res_b_q <= PW'(quot);
						state_q <= S_OUT;
					end
				end
				S_PC: begin
					if (div_st.done) begin
						pc_q    <= GW'(quot);
						state_q <= S_PR;
					end
				end
				S_PR: begin
					if (start) pc_ok_q <= pc_ok_d;
					if (div_st.done) begin
						pr_q    <= GW'(quot);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_r_q    <= pix_r_q;
					res_g_q    <= pix_g_q;
					res_b_q    <= pix_b_q;
					res_col_q  <= IW'(pc_q);
					res_row_q  <= IW'(pr_q);
					res_done_q <= (pc_q == gc - 1'b1) && (pr_q == gr - 1'b1);
					state_q    <= (pc_ok_q && pr_ok_d) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_col_q   <= res_col_q;
						out_row_q   <= res_row_q;
						out_r_q     <= res_r_q;
						out_g_q     <= res_g_q;
						out_b_q     <= res_b_q;
						out_done_q  <= res_done_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign cell_column = out_col_q;
	assign cell_row    = out_row_q;
	assign cell_red    = out_r_q;
	assign cell_green  = out_g_q;
	assign cell_blue   = out_b_q;
	assign frame_done  = out_done_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block idle right after taking a pixel");

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> div_state && div_run_q)
		else $error("divider finished outside a divide step");

	a_frame_done_last_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> (GW'(cell_column) == gc - 1'b1) &&
		(GW'(cell_row) == gr - 1'b1))
		else $error("frame end flagged on a cell that is not the last");

endmodule
